>>> design/bounded_double_ended_queue_unit_assert.svh
// ----------------------------------------------------------------------------
// Deque unit assertion macros
// Concurrent assertion helpers clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge out of reset.
`define BDEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true out of reset.
`define BDEQ_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define BDEQ_ASSERT(lbl, prop, msg)
`define BDEQ_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

>>> design/bdeq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque package
// Shared sizes, command and status codes, and the cell control word.
// ----------------------------------------------------------------------------
package bdeq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_DUMP       = 3'd4;

  typedef logic signed [31:0] data_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD    = 3'd0,
    OP_SHIFT_R = 3'd1,
    OP_SHIFT_L = 3'd2,
    OP_WRITE   = 3'd3,
    OP_ROTATE  = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [CNT_W-1:0]  count;
    data_t             value;
  } cell_ctrl_t;

endpackage

>>> design/bdeq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque channel interfaces
// Valid/ready channels for command beats in and result beats out.
// ----------------------------------------------------------------------------
interface bdeq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic signed [31:0] push_value;

  modport source (output valid, output cmd, output push_value, input ready);
  modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface bdeq_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] out_value;
  logic [1:0]  status;
  logic        last_of_run;

  modport source (output valid, output out_value, output status, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_value, input status, input last_of_run,
                  output ready);
endinterface

>>> design/bounded_double_ended_queue_unit.sv
`timescale 1ns / 1ps
// Pushes and pops: result beat registered in the cycle after the command beat; one command per cycle
// while results are taken, set by the shift of the cell chain.
// Dump of N entries: accepted, then N result beats, one per cycle while results are taken, as the chain
// rotates once through the front cell; the next command is taken after the last beat is loaded.
// Reset clears the entry count, control state and output valid; cell contents are left as they are.
// ----------------------------------------------------------------------------
// Bounded double-ended queue unit
// Deque of signed 32-bit values held in a shifting chain of cells.
// ----------------------------------------------------------------------------
`include "bounded_double_ended_queue_unit_assert.svh"

module bounded_double_ended_queue_unit (
  input  logic        clk,
  input  logic        rst_n,
  bdeq_in_if.sink     in_ch,
  bdeq_out_if.source  out_ch
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  localparam int CNT_W = bdeq_pkg::CNT_W;
  localparam int IDX_W = bdeq_pkg::IDX_W;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [IDX_W-1:0]      dump_idx_r, dump_idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  bdeq_pkg::data_t       out_value_r;
  bdeq_pkg::status_t     out_status_r;
  logic                  out_last_r;

  bdeq_pkg::cell_ctrl_t  ctrl;
  bdeq_pkg::data_t       head_value;
  bdeq_pkg::data_t       tail_value;

  logic                  slot_free;
  logic                  accept;
  logic                  full;
  logic                  empty;
  logic                  load;
  bdeq_pkg::data_t       res_value;
  bdeq_pkg::status_t     res_status;
  logic                  res_last;
  logic                  dump_last;

  bdeq_chain u_chain (
    .clk        (clk),
    .ctrl       (ctrl),
    .head_value (head_value),
    .tail_value (tail_value)
  );

  assign slot_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && slot_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CNT_W'(bdeq_pkg::DEPTH));
  assign empty       = (count_r == '0);
  assign dump_last   = ((CNT_W'(dump_idx_r) + CNT_W'(1)) == count_r);

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    dump_idx_nxt = dump_idx_r;
    ctrl.op      = bdeq_pkg::OP_HOLD;
    ctrl.count   = count_r;
    ctrl.value   = in_ch.push_value;
    load         = 1'b0;
    res_value    = '0;
    res_status   = bdeq_pkg::ST_OK;
    res_last     = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_ch.cmd)
            bdeq_pkg::CMD_PUSH_FRONT: begin
              load = 1'b1;
              if (full) begin
                res_status = bdeq_pkg::ST_FULL;
              end else begin
                ctrl.op   = bdeq_pkg::OP_SHIFT_R;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            bdeq_pkg::CMD_PUSH_BACK: begin
              load = 1'b1;
              if (full) begin
                res_status = bdeq_pkg::ST_FULL;
              end else begin
                ctrl.op   = bdeq_pkg::OP_WRITE;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            bdeq_pkg::CMD_POP_FRONT: begin
              load = 1'b1;
              if (empty) begin
                res_status = bdeq_pkg::ST_EMPTY;
              end else begin
                res_value = head_value;
                ctrl.op   = bdeq_pkg::OP_SHIFT_L;
                count_nxt = count_r - CNT_W'(1);
              end
            end
            bdeq_pkg::CMD_POP_BACK: begin
              load = 1'b1;
              if (empty) begin
                res_status = bdeq_pkg::ST_EMPTY;
              end else begin
                res_value = tail_value;
                count_nxt = count_r - CNT_W'(1);
              end
            end
            bdeq_pkg::CMD_DUMP: begin
              if (empty) begin
                load       = 1'b1;
                res_status = bdeq_pkg::ST_EMPTY;
              end else begin
                state_nxt    = S_DUMP;
                dump_idx_nxt = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_DUMP: begin
        // Each beat shows the front cell and rotates the chain by one place.
        if (slot_free) begin
          load         = 1'b1;
          res_value    = head_value;
          res_last     = dump_last;
          ctrl.op      = bdeq_pkg::OP_ROTATE;
          dump_idx_nxt = dump_idx_r + IDX_W'(1);
          if (dump_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      dump_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dump_idx_r  <= dump_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_value_r  <= res_value;
      out_status_r <= res_status;
      out_last_r   <= res_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_value   = out_value_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.last_of_run = out_last_r;

  `BDEQ_ASSERT_NEVER(a_count_range, count_r > CNT_W'(bdeq_pkg::DEPTH), "entry count over depth")
  `BDEQ_ASSERT(a_dump_idx, (state_r == S_DUMP) |-> (CNT_W'(dump_idx_r) < count_r), "dump index past tail")
  `BDEQ_ASSERT(a_push_count, (accept && !full && (in_ch.cmd == bdeq_pkg::CMD_PUSH_FRONT || in_ch.cmd == bdeq_pkg::CMD_PUSH_BACK)) |=> (count_r == $past(count_r) + CNT_W'(1)), "push did not grow count")
  `BDEQ_ASSERT(a_dump_hold, (state_r == S_DUMP) |=> (count_r == $past(count_r)), "count changed during dump")
  `BDEQ_ASSERT(a_load_free, load |-> slot_free, "result loaded over a waiting beat")

endmodule

>>> design/bdeq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque cell
// One storage slot of the chain; takes data from a neighbor or the command.
// ----------------------------------------------------------------------------
module bdeq_cell (
  input  logic                         clk,
  input  logic [bdeq_pkg::IDX_W-1:0]   cell_idx,
  input  bdeq_pkg::cell_ctrl_t         ctrl,
  input  bdeq_pkg::data_t              left_value,
  input  bdeq_pkg::data_t              right_value,
  input  bdeq_pkg::data_t              head_value,
  output bdeq_pkg::data_t              value,
  output logic                         is_tail
);

  bdeq_pkg::data_t               value_r;
  bdeq_pkg::data_t               value_nxt;
  logic [bdeq_pkg::CNT_W-1:0]    idx_ext;
  logic                          at_count;

  assign idx_ext  = bdeq_pkg::CNT_W'(cell_idx);
  assign at_count = (idx_ext == ctrl.count);
  assign is_tail  = ((idx_ext + bdeq_pkg::CNT_W'(1)) == ctrl.count);

  always_comb begin
    value_nxt = value_r;
    unique case (ctrl.op)
      bdeq_pkg::OP_HOLD:    value_nxt = value_r;
      bdeq_pkg::OP_SHIFT_R: value_nxt = left_value;
      bdeq_pkg::OP_SHIFT_L: value_nxt = right_value;
      bdeq_pkg::OP_WRITE: begin
        if (at_count) value_nxt = ctrl.value;
      end
      // The tail cell closes the ring so the contents come back after a full pass.
      bdeq_pkg::OP_ROTATE:  value_nxt = is_tail ? head_value : right_value;
      default:              value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

>>> design/bdeq_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque cell chain
// Row of cells with the front in cell zero; also picks out the tail entry.
// ----------------------------------------------------------------------------
module bdeq_chain (
  input  logic                  clk,
  input  bdeq_pkg::cell_ctrl_t  ctrl,
  output bdeq_pkg::data_t       head_value,
  output bdeq_pkg::data_t       tail_value
);

  bdeq_pkg::data_t  vals [bdeq_pkg::DEPTH];
  logic             tails [bdeq_pkg::DEPTH];

  for (genvar i = 0; i < bdeq_pkg::DEPTH; i++) begin : g_cell
    bdeq_pkg::data_t left_v;
    bdeq_pkg::data_t right_v;

    if (i == 0) begin : g_first
      assign left_v = ctrl.value;
    end else begin : g_mid
      assign left_v = vals[i-1];
    end

    if (i == bdeq_pkg::DEPTH - 1) begin : g_last
      assign right_v = vals[i];
    end else begin : g_inner
      assign right_v = vals[i+1];
    end

    bdeq_cell u_cell (
      .clk         (clk),
      .cell_idx    (bdeq_pkg::IDX_W'(i)),
      .ctrl        (ctrl),
      .left_value  (left_v),
      .right_value (right_v),
      .head_value  (vals[0]),
      .value       (vals[i]),
      .is_tail     (tails[i])
    );
  end

  assign head_value = vals[0];

  always_comb begin
    tail_value = '0;
    for (int i = 0; i < bdeq_pkg::DEPTH; i++) begin
      if (tails[i]) tail_value = tail_value | vals[i];
    end
  end

endmodule
